### hw/rtl/u2af_pkg.sv
package u2af_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned CAP_W   = 8;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_UPPERCASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'd1;

  localparam logic       UPPERCASE_RST = 1'b0;
  localparam logic [CAP_W-1:0] CAPACITY_RST = 8'd255;

  // Source bytes with a meaning of their own
  localparam logic [BYTE_W-1:0] B_NUL      = 8'h00;
  localparam logic [BYTE_W-1:0] B_LEAD_E2  = 8'hE2;
  localparam logic [BYTE_W-1:0] B_CONT_80  = 8'h80;
  localparam logic [BYTE_W-1:0] B_EN_DASH  = 8'h93;
  localparam logic [BYTE_W-1:0] B_EM_DASH  = 8'h94;
  localparam logic [BYTE_W-1:0] B_LEAD_C2  = 8'hC2;
  localparam logic [BYTE_W-1:0] B_MID_DOT  = 8'hB7;
  localparam logic [BYTE_W-1:0] B_LEAD_C3  = 8'hC3;

  localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;
  localparam logic [CHAR_W-1:0] CH_QUEST = 7'h3F;
  localparam logic [CHAR_W-1:0] CH_DASH  = 7'h2D;

  // One result beat
  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              is_end;
  } res_t;

  // Fold a Latin-1 letter (second byte of a C3 pair, low six bits) to ASCII
  function automatic logic [CHAR_W-1:0] fold_latin1(input logic [5:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6: c = 7'h41; // A
      6'd7:                              c = 7'h43; // C
      6'd8, 6'd9, 6'd10, 6'd11:          c = 7'h45; // E
      6'd12, 6'd13, 6'd14, 6'd15:        c = 7'h49; // I
      6'd16:                             c = 7'h44; // D
      6'd17:                             c = 7'h4E; // N
      6'd18, 6'd19, 6'd20, 6'd21, 6'd22: c = 7'h4F; // O
      6'd23:                             c = 7'h78; // x
      6'd24:                             c = 7'h4F; // O
      6'd25, 6'd26, 6'd27, 6'd28:        c = 7'h55; // U
      6'd29:                             c = 7'h59; // Y
      6'd30:                             c = 7'h54; // T
      6'd31:                             c = 7'h73; // s
      6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38: c = 7'h61; // a
      6'd39:                             c = 7'h63; // c
      6'd40, 6'd41, 6'd42, 6'd43:        c = 7'h65; // e
      6'd44, 6'd45, 6'd46, 6'd47:        c = 7'h69; // i
      6'd48:                             c = 7'h64; // d
      6'd49:                             c = 7'h6E; // n
      6'd50, 6'd51, 6'd52, 6'd53, 6'd54: c = 7'h6F; // o
      6'd55:                             c = 7'h2F; // /
      6'd56:                             c = 7'h6F; // o
      6'd57, 6'd58, 6'd59, 6'd60:        c = 7'h75; // u
      6'd61:                             c = 7'h79; // y
      6'd62:                             c = 7'h74; // t
      6'd63:                             c = 7'h79; // y
      default:                           c = CH_QUEST;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] upcase(input logic [CHAR_W-1:0] c,
                                               input logic en);
    logic [CHAR_W-1:0] r;
    r = c;
    if (en && c >= 7'h61 && c <= 7'h7A) begin
      r = c - 7'h20;
    end
    return r;
  endfunction

endpackage

### hw/rtl/u2af_if.sv
interface u2af_in_if;
  logic                          valid;
  logic                          ready;
  logic [u2af_pkg::BYTE_W-1:0]   in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u2af_out_if;
  logic                          valid;
  logic                          ready;
  logic [u2af_pkg::CHAR_W-1:0]   out_char;
  logic                          is_end;

  modport source (output valid, output out_char, output is_end, input ready);
  modport sink   (input valid, input out_char, input is_end, output ready);
endinterface

### hw/rtl/utf8_to_ascii_fold_unit.sv
// Channel  | Dir | Payload                     | Beat taken when
// ---------+-----+-----------------------------+------------------------------
// in_bus   | in  | in_byte[7:0]                | in_bus.valid & in_bus.ready
// out_bus  | out | out_char[6:0], is_end       | out_bus.valid & out_bus.ready
// cfg_*    | in  | cfg_index[0], cfg_wdata[7:0]| cfg_we
//
// One source byte is decoded in the cycle it is taken; its zero, one or two
// result beats land in a three-entry result queue and show in the next cycle.
// One byte per cycle is sustained while each byte yields at most one beat
// and out_bus.ready stays high; a byte yielding two beats drops in_bus.ready.
// in_bus.ready is a register: high while the queue holds at most one beat.
// rst_n is synchronous, active low: it clears the decoder, the character
// count, the queue and the registers to their defaults.
module utf8_to_ascii_fold_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  u2af_in_if.sink                           in_bus,
  u2af_out_if.source                        out_bus,
  input  logic                              cfg_we,
  input  logic [u2af_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [u2af_pkg::CFG_W-1:0]        cfg_wdata
);

  // Decoder phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SKIP = 3'd1;
  localparam logic [2:0] PH_E2A  = 3'd2;
  localparam logic [2:0] PH_E2B  = 3'd3;
  localparam logic [2:0] PH_C2A  = 3'd4;
  localparam logic [2:0] PH_C3A  = 3'd5;

  localparam int unsigned QDEPTH = 3;

  logic                               upper_r;
  logic [u2af_pkg::CAP_W-1:0]         cap_r;
  logic [2:0]                         phase_r, phase_nxt;
  logic [u2af_pkg::CAP_W-1:0]         cw_r, cw_nxt;

  u2af_pkg::res_t                     q_r [QDEPTH];
  u2af_pkg::res_t                     q_nxt [QDEPTH];
  logic [1:0]                         cnt_r, cnt_nxt;
  logic                               rdy_r, rdy_nxt;

  logic                               accept, pop;
  logic [u2af_pkg::BYTE_W-1:0]        b;
  logic                               b_cont;

  // decode scratch
  logic                               put_a;
  logic [u2af_pkg::CHAR_W-1:0]        char_a;
  logic                               do_lead;
  logic [2:0]                         ph_alt;
  logic                               emit_a, emit_b;
  u2af_pkg::res_t                     res_a, res_b, slot0, slot1;
  logic [u2af_pkg::CAP_W:0]           cw1;
  logic [u2af_pkg::CAP_W:0]           cw_ext;
  logic [1:0]                         nres, base;

  assign accept = in_bus.valid & rdy_r;
  assign pop    = out_bus.valid & out_bus.ready;
  assign b      = in_bus.in_byte;
  assign b_cont = (b[7:6] == 2'b10);

  assign in_bus.ready     = rdy_r;
  assign out_bus.valid    = (cnt_r != 2'd0);
  assign out_bus.out_char = q_r[0].out_char;
  assign out_bus.is_end   = q_r[0].is_end;

  // Phase decode: an optional first character, then either a new lead byte
  // or a plain phase change.
  always_comb begin
    put_a   = 1'b0;
    char_a  = u2af_pkg::CH_QUEST;
    do_lead = 1'b0;
    ph_alt  = PH_IDLE;
    case (phase_r)
      PH_SKIP: begin
        if (b_cont) begin
          ph_alt = PH_SKIP;
        end else begin
          do_lead = 1'b1;
        end
      end
      PH_E2A: begin
        if (b == u2af_pkg::B_CONT_80) begin
          ph_alt = PH_E2B;
        end else begin
          put_a = 1'b1;
          if (b_cont) ph_alt = PH_SKIP;
          else        do_lead = 1'b1;
        end
      end
      PH_E2B: begin
        if (b == u2af_pkg::B_EN_DASH || b == u2af_pkg::B_EM_DASH) begin
          put_a  = 1'b1;
          char_a = u2af_pkg::CH_DASH;
        end else begin
          put_a = 1'b1;
          if (b_cont) ph_alt = PH_SKIP;
          else        do_lead = 1'b1;
        end
      end
      PH_C2A: begin
        if (b == u2af_pkg::B_MID_DOT) begin
          put_a  = 1'b1;
          char_a = u2af_pkg::CH_DASH;
        end else begin
          put_a = 1'b1;
          if (b_cont) ph_alt = PH_SKIP;
          else        do_lead = 1'b1;
        end
      end
      PH_C3A: begin
        put_a = 1'b1;
        if (b == u2af_pkg::B_NUL) begin
          do_lead = 1'b1;
        end else if (b_cont) begin
          char_a = u2af_pkg::fold_latin1(b[5:0]);
        end
      end
      default: begin
        do_lead = 1'b1;
      end
    endcase
  end

  // Capacity gate and the lead-byte handler
  always_comb begin
    cw_ext = {1'b0, cw_r};
    emit_a = put_a && ((cw_ext + 1'b1) < {1'b0, cap_r});
    res_a.out_char = u2af_pkg::upcase(char_a, upper_r);
    res_a.is_end   = 1'b0;
    cw1 = cw_ext + {{u2af_pkg::CAP_W{1'b0}}, emit_a};

    emit_b         = 1'b0;
    res_b.out_char = u2af_pkg::upcase(b[6:0], upper_r);
    res_b.is_end   = 1'b0;
    cw_nxt         = cw1[u2af_pkg::CAP_W-1:0];
    phase_nxt      = ph_alt;
    if (do_lead) begin
      if (b == u2af_pkg::B_NUL) begin
        // terminator: shown whenever there is room for anything at all
        emit_b         = (cap_r != '0);
        res_b.out_char = u2af_pkg::CH_NUL;
        res_b.is_end   = 1'b1;
        cw_nxt         = '0;
        phase_nxt      = PH_IDLE;
      end else if (!b[7]) begin
        emit_b    = (cw1 + 1'b1) < {1'b0, cap_r};
        phase_nxt = PH_IDLE;
      end else if (b == u2af_pkg::B_LEAD_E2) begin
        phase_nxt = PH_E2A;
      end else if (b == u2af_pkg::B_LEAD_C2) begin
        phase_nxt = PH_C2A;
      end else if (b == u2af_pkg::B_LEAD_C3) begin
        phase_nxt = PH_C3A;
      end else begin
        emit_b         = (cw1 + 1'b1) < {1'b0, cap_r};
        res_b.out_char = u2af_pkg::upcase(u2af_pkg::CH_QUEST, upper_r);
        phase_nxt      = PH_SKIP;
      end
      if (b != u2af_pkg::B_NUL) begin
        cw_nxt = cw1[u2af_pkg::CAP_W-1:0] + {{(u2af_pkg::CAP_W-1){1'b0}}, emit_b};
      end
    end
  end

  // Result queue: shift out at the head, append compacted results behind
  always_comb begin
    slot0 = emit_a ? res_a : res_b;
    slot1 = res_b;
    nres  = {1'b0, emit_a} + {1'b0, emit_b};
    if (!accept) nres = 2'd0;
    base  = cnt_r - {1'b0, pop};

    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) q_nxt[i] = q_r[i+1];
      else                       q_nxt[i] = q_r[i];
    end
    for (int i = 0; i < QDEPTH; i++) begin
      if (nres != 2'd0 && base == i[1:0]) q_nxt[i] = slot0;
      if (nres == 2'd2 && (base + 2'd1) == i[1:0]) q_nxt[i] = slot1;
    end
    cnt_nxt = base + nres;
    rdy_nxt = (cnt_nxt <= 2'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= u2af_pkg::UPPERCASE_RST;
      cap_r   <= u2af_pkg::CAPACITY_RST;
      phase_r <= PH_IDLE;
      cw_r    <= '0;
      cnt_r   <= 2'd0;
      rdy_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          u2af_pkg::CFG_UPPERCASE: upper_r <= cfg_wdata[0];
          u2af_pkg::CFG_CAPACITY:  cap_r   <= cfg_wdata[u2af_pkg::CAP_W-1:0];
          default: ;
        endcase
      end
      // advance the decoder only on a taken beat
      if (accept) begin
        phase_r <= phase_nxt;
        cw_r    <= cw_nxt;
      end
      cnt_r <= cnt_nxt;
      rdy_r <= rdy_nxt;
    end
  end

  // queue payload: no reset, guarded by cnt_r
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

### bench/ascii_fold_checker.sv
module ascii_fold_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  u2af_in_if                             in_mon,
  u2af_out_if                            out_mon,
  input  logic                           cfg_we,
  input  logic [u2af_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [u2af_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             mismatches,
  output int                             outstanding,
  output int                             beats_checked
);
  import u2af_pkg::*;

  localparam int MAX_PRINTS = 40;
  localparam logic [CHAR_W-1:0] ASC_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] ASC_LOWER_Z = 7'h7A;
  localparam logic [CHAR_W-1:0] CASE_SHIFT  = 7'h20;
  // Latin-1 letters C3 80..C3 BF folded to plain ASCII, first entry leftmost
  localparam logic [8*64-1:0] LATIN1_FOLD =
    "AAAAAAACEEEEIIIIDNOOOOOxOUUUUYTsaaaaaaaceeeeiiiidnooooo/ouuuuyty";

  typedef enum logic [2:0] {
    DS_IDLE, DS_SKIP, DS_E2_LEAD, DS_E2_MID, DS_C2_LEAD, DS_C3_LEAD
  } dec_state_e;

  dec_state_e        dec_state;
  logic              upper_en;
  logic [CAP_W-1:0]  dest_size;
  int                chars_in_string;
  res_t              pending_chars[$];
  res_t              oldest;

  initial begin
    mismatches    = 0;
    outstanding   = 0;
    beats_checked = 0;
  end

  function automatic bit is_cont(input logic [BYTE_W-1:0] b);
    return b[7:6] == 2'b10;
  endfunction

  // Queue one character unless the destination is full
  function automatic void emit_char(input logic [CHAR_W-1:0] c);
    res_t r;
    if (chars_in_string + 1 >= int'(dest_size)) return;
    r.out_char = c;
    if (upper_en && c >= ASC_LOWER_A && c <= ASC_LOWER_Z) r.out_char = c - CASE_SHIFT;
    r.is_end = 1'b0;
    pending_chars.push_back(r);
    chars_in_string++;
  endfunction

  function automatic void take_lead(input logic [BYTE_W-1:0] b);
    res_t r;
    dec_state = DS_IDLE;
    if (b == B_NUL) begin
      if (dest_size != 0) begin
        r.out_char = CH_NUL;
        r.is_end   = 1'b1;
        pending_chars.push_back(r);
      end
      chars_in_string = 0;
    end else if (!b[7]) begin
      emit_char(b[CHAR_W-1:0]);
    end else if (b == B_LEAD_E2) begin
      dec_state = DS_E2_LEAD;
    end else if (b == B_LEAD_C2) begin
      dec_state = DS_C2_LEAD;
    end else if (b == B_LEAD_C3) begin
      dec_state = DS_C3_LEAD;
    end else begin
      emit_char(CH_QUEST);
      dec_state = DS_SKIP;
    end
  endfunction

  // Broken multi-byte sequence: flag it, then skip or re-read this byte
  function automatic void break_sequence(input logic [BYTE_W-1:0] b);
    emit_char(CH_QUEST);
    if (is_cont(b)) dec_state = DS_SKIP;
    else take_lead(b);
  endfunction

  function automatic void fold_byte(input logic [BYTE_W-1:0] b);
    int idx;
    case (dec_state)
      DS_SKIP: begin
        if (!is_cont(b)) take_lead(b);
      end
      DS_E2_LEAD: begin
        if (b == B_CONT_80) dec_state = DS_E2_MID;
        else break_sequence(b);
      end
      DS_E2_MID: begin
        if (b == B_EN_DASH || b == B_EM_DASH) begin
          emit_char(CH_DASH);
          dec_state = DS_IDLE;
        end else begin
          break_sequence(b);
        end
      end
      DS_C2_LEAD: begin
        if (b == B_MID_DOT) begin
          emit_char(CH_DASH);
          dec_state = DS_IDLE;
        end else begin
          break_sequence(b);
        end
      end
      DS_C3_LEAD: begin
        if (b == B_NUL) begin
          emit_char(CH_QUEST);
          take_lead(B_NUL);
        end else begin
          idx = int'(b[5:0]);
          if (is_cont(b)) emit_char(LATIN1_FOLD[(63 - idx) * 8 +: CHAR_W]);
          else emit_char(CH_QUEST);
          dec_state = DS_IDLE;
        end
      end
      default: begin
        take_lead(b);
      end
    endcase
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] fold check: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dec_state       = DS_IDLE;
      upper_en        = UPPERCASE_RST;
      dest_size       = CAPACITY_RST;
      chars_in_string = 0;
      pending_chars.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_UPPERCASE: upper_en  = cfg_wdata[0];
          CFG_CAPACITY:  dest_size = cfg_wdata[CAP_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        beats_checked++;
        if (pending_chars.size() == 0) begin
          report($sformatf("unexpected beat char=%02h end=%0b",
                           out_mon.out_char, out_mon.is_end));
        end else begin
          oldest = pending_chars.pop_front();
          if (out_mon.out_char !== oldest.out_char)
            report($sformatf("out_char %02h, want %02h", out_mon.out_char, oldest.out_char));
          if (out_mon.is_end !== oldest.is_end)
            report($sformatf("is_end %0b, want %0b", out_mon.is_end, oldest.is_end));
        end
      end
      if (in_mon.valid && in_mon.ready) fold_byte(in_mon.in_byte);
    end
    outstanding <= pending_chars.size();
  end

endmodule

### bench/tb.sv
module tb;
  import u2af_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 12;
  localparam int LIMIT_CYCLES    = 1000000;
  localparam int RANDOM_BYTES    = 850;
  localparam int HOLD_OFF_CYCLES = 300;
  // quiet cycles before the registers change
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 20;
  localparam int LONG_STRING     = 258;

  // Opening bytes: every fold rule once, the field extremes and the broken forms
  localparam logic [BYTE_W-1:0] OPENING [27] = '{
    8'h7F,                                   // top of plain ASCII
    B_LEAD_E2, B_CONT_80, B_EN_DASH,         // en dash
    B_LEAD_E2, B_CONT_80, B_EM_DASH,         // em dash
    B_LEAD_C2, B_MID_DOT,                    // middle dot
    B_LEAD_C3, B_CONT_80,                    // first Latin-1 fold entry
    B_LEAD_C3, 8'h41,                        // C3 with a low second byte
    B_LEAD_C3, 8'hC5,                        // C3 with a lead as second byte
    B_LEAD_C3, B_NUL,                        // C3 cut by the terminator
    8'hBF, 8'hFF, B_CONT_80,                 // stray continuation, odd lead, skip
    B_LEAD_E2, B_CONT_80, 8'h61,             // dash broken on its last byte
    B_LEAD_C2, B_LEAD_C3, 8'hA9,             // dot broken by a new lead
    B_NUL
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  u2af_in_if  in_bus ();
  u2af_out_if out_bus ();

  int mismatches;
  int outstanding;
  int beats_checked;

  int bytes_sent    = 0;
  int settings_used = 0;
  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int hold_requests = 0;

  utf8_to_ascii_fold_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ascii_fold_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .beats_checked (beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs or drops a beat
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("CHECKS FAILED");
    $finish;
  end

  // Idle length: picked at random, now and then a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random back-pressure, plus one long hold-off on request.
  // The hold-off is counted here so the sender keeps offering bytes meanwhile.
  initial begin : result_sink
    int stall_left;
    int holds_seen;
    stall_left = 0;
    holds_seen = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        if (holds_seen != hold_requests) begin
          holds_seen = hold_requests;
          stall_left = HOLD_OFF_CYCLES;
        end else if ($urandom_range(0, 99) < rx_idle_pct) begin
          stall_left = pick_gap();
        end
      end
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Offer one byte, maybe after an idle gap, and hold it until it is taken.
  // Valid stays high across back-to-back beats.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = ($urandom_range(0, 99) < tx_idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.in_byte <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // One character's worth of source bytes: clean UTF-8, or a broken form
  task automatic send_token(input bit clean);
    int kind;
    logic [BYTE_W-1:0] b;
    if (clean) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        send_byte(8'($urandom_range(1, 127)));
      end else if (kind == 5) begin
        send_byte(B_LEAD_E2);
        send_byte(B_CONT_80);
        send_byte($urandom_range(0, 1) ? B_EN_DASH : B_EM_DASH);
      end else if (kind == 6) begin
        send_byte(B_LEAD_C2);
        send_byte(B_MID_DOT);
      end else begin
        send_byte(B_LEAD_C3);
        send_byte(8'($urandom_range(8'h80, 8'hBF)));
      end
    end else begin
      kind = $urandom_range(0, 6);
      case (kind)
        0: begin
          send_byte(B_LEAD_E2);
          send_byte(8'($urandom_range(0, 255)));
        end
        1: begin
          send_byte(B_LEAD_E2);
          send_byte(B_CONT_80);
          send_byte(8'($urandom_range(0, 255)));
        end
        2: begin
          send_byte(B_LEAD_C2);
          send_byte(8'($urandom_range(0, 255)));
        end
        3: begin
          send_byte(B_LEAD_C3);
          if ($urandom_range(0, 1)) send_byte(8'($urandom_range(1, 8'h7F)));
          else send_byte(8'($urandom_range(8'hC0, 8'hFF)));
        end
        4: begin
          send_byte(B_LEAD_C3);
          send_byte(B_NUL);
        end
        5: begin
          // unsupported lead or stray continuation, then a run to skip
          do b = 8'($urandom_range(8'h80, 8'hFF));
          while (b == B_LEAD_E2 || b == B_LEAD_C2 || b == B_LEAD_C3);
          send_byte(b);
          repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(8'h80, 8'hBF)));
        end
        default: begin
          send_byte(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  // Mostly clean text with some noise; optionally leave the string open
  task automatic send_string(input int tokens, input bit close);
    repeat (tokens) send_token($urandom_range(0, 99) < 80);
    if (close) send_byte(B_NUL);
  endtask

  // Write both registers; only called while nothing is in flight
  task automatic set_config(input logic up, input logic [CAP_W-1:0] size);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_UPPERCASE;
    cfg_wdata <= CFG_W'(up);
    @(posedge clk);
    cfg_index <= CFG_CAPACITY;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Drop valid and wait until every predicted beat has come out
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int phase_no;
    int budget;
    int r;
    logic up;
    logic [CAP_W-1:0] size;

    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.in_byte = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_UPPERCASE;
    cfg_wdata      = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening bytes run at the reset register values
    tx_idle_pct = 30;
    rx_idle_pct = 10;
    foreach (OPENING[i]) send_byte(OPENING[i]);
    wait_drained();

    // Phases of random text; the first few pin the register extremes
    phase_no = 0;
    while (bytes_sent < $size(OPENING) + RANDOM_BYTES) begin
      case (phase_no)
        0: begin
          up = 1'b0; size = 8'd0;
        end
        1: begin
          up = 1'b1; size = 8'd1;
        end
        2: begin
          up = 1'b1; size = 8'd255;
        end
        3: begin
          up = 1'b0; size = 8'd2;
        end
        default: begin
          up = 1'($urandom_range(0, 1));
          r  = $urandom_range(0, 9);
          if (r < 4) size = 8'($urandom_range(0, 8));
          else if (r < 6) size = 8'd255;
          else size = 8'($urandom_range(0, 255));
        end
      endcase
      set_config(up, size);

      // Some phases run with no idling at all
      r = $urandom_range(0, 2);
      tx_idle_pct = (r == 0) ? 0 : (r == 1) ? 20 : 50;
      r = $urandom_range(0, 2);
      rx_idle_pct = (r == 0) ? 0 : (r == 1) ? 10 : 30;

      if (phase_no == 2) begin
        // Fill a full-size destination past its end while the sink holds off,
        // so the result queue fills up and the input stalls.
        tx_idle_pct = 0;
        hold_requests++;
        repeat (LONG_STRING) send_byte(8'($urandom_range(1, 127)));
        send_byte(B_NUL);
      end

      budget = bytes_sent + $urandom_range(30, 90);
      while (bytes_sent < budget) send_string($urandom_range(0, 12), 1'b1);
      // Leave a string open so the next settings land mid-string
      if ($urandom_range(0, 1)) send_string($urandom_range(1, 4), 1'b0);
      wait_drained();
      phase_no++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d source bytes and %0d result beats over %0d register settings,",
             bytes_sent, beats_checked, settings_used);
    $display("with capacity from 0 to 255, uppercase on and off, and a long output stall.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
